// ----- src/epoch_to_calendar_datetime_defines.svh -----
// Assertion macros for the epoch to calendar conversion block.
// Included by files that carry concurrent checks; expects i_clk and i_rst_n in scope.
`ifndef EPOCH_TO_CALENDAR_DATETIME_DEFINES_SVH
`define EPOCH_TO_CALENDAR_DATETIME_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define E2C_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("epoch_to_calendar_datetime: check failed");
`define E2C_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("epoch_to_calendar_datetime: check failed");
`else
`define E2C_ASSERT_IMPLY(lbl, ante, cons)
`define E2C_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- src/e2c_pkg.sv -----
// Shared constants and types for the epoch to calendar conversion block.
// No dependencies.
`timescale 1ns / 1ps

package e2c_pkg;

    localparam int EPOCH_WIDTH_DEF = 32;
    localparam int NSTG            = 9;

    // seconds per day = 2^7 * 675
    localparam int DAY_SHIFT    = 7;
    localparam int DAY_ODD      = 675;
    localparam int DAY_ODD_BITS = 10;
    localparam int SEC_PER_DAY  = 86400;
    localparam int SEC_PER_HOUR = 3600;
    localparam int SEC_PER_MIN  = 60;

    // days from 0000-03-01 to 1970-01-01, and days per 400 years
    localparam int CIVIL_OFFSET = 719468;
    localparam int DAYS_PER_ERA = 146097;
    localparam int YEARS_ERA    = 400;
    localparam int DAYS_YEAR    = 365;
    localparam int DAYS_CENT    = 36524;
    localparam int DAYS_4Y      = 1460;

    // reciprocals for exact division by constants
    localparam int M_HOUR = 149131;   // /3600, shift 29
    localparam int M_MIN  = 4370;     // /60,   shift 18
    localparam int M_1460 = 367720;   // /1460, shift 29
    localparam int M_365  = 1470880;  // /365,  shift 29
    localparam int M_100  = 656;      // /100,  shift 16
    localparam int M_153  = 3427;     // /153,  shift 19
    localparam int M_DIV5 = 13108;    // /5,    shift 16

    localparam int MP_WRAP = 10;      // March-based month index of January

    typedef logic [NSTG-1:0] t_stage_en;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_tod;

endpackage

// ----- src/e2c_in_if.sv -----
// Request channel carrying the epoch seconds count.
// Depends on e2c_pkg.
`timescale 1ns / 1ps

interface e2c_in_if #(
    parameter int EPOCH_WIDTH = e2c_pkg::EPOCH_WIDTH_DEF
);
    logic                   valid;
    logic                   ready;
    logic [EPOCH_WIDTH-1:0] epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

// ----- src/e2c_out_if.sv -----
// Result channel carrying the calendar date and time of day.
// No dependencies.
`timescale 1ns / 1ps

interface e2c_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;

    modport source (output valid, output year, output month, output day_of_month,
                    output hour, output minute, output second, input ready);
    modport sink   (input valid, input year, input month, input day_of_month,
                    input hour, input minute, input second, output ready);
endinterface

// ----- src/epoch_to_calendar_datetime.sv -----
// Epoch seconds to Gregorian date and time of day, nine-stage pipeline.
// Depends on e2c_pkg, e2c_in_if, e2c_out_if, e2c_civil and the defines header.
//
//  channel  dir  handshake              payload
//  i_req    in   valid/ready, request   epoch_seconds
//  o_rsp    out  valid/ready, request   year, month, day_of_month, hour, minute, second
//
// One request per cycle when o_rsp.ready stays high.
// The constant-reciprocal multipliers are spread over the stages, at most two per stage.
// A stall at o_rsp freezes only occupied stages; empty stages keep filling.
// Reset clears the valid chain; no clearing pass.
`timescale 1ns / 1ps
`include "epoch_to_calendar_datetime_defines.svh"

module epoch_to_calendar_datetime #(
    parameter int EPOCH_WIDTH = e2c_pkg::EPOCH_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    e2c_in_if.sink      i_req,
    e2c_out_if.source   o_rsp
);

    localparam int NSTG = e2c_pkg::NSTG;
    localparam int XW   = EPOCH_WIDTH - e2c_pkg::DAY_SHIFT;
    localparam int DW   = EPOCH_WIDTH - 16;
    localparam int ZW   = (DW + 1 > 20) ? DW + 1 : 20;
    localparam int DayK = XW + e2c_pkg::DAY_ODD_BITS;
    localparam logic [XW:0] DayM =
        (XW+1)'(((64'd1 << DayK) + 64'(e2c_pkg::DAY_ODD) - 64'd1)
                / 64'(e2c_pkg::DAY_ODD));

    logic [NSTG-1:0]    r_vld;
    e2c_pkg::t_stage_en w_en;

    logic [2*XW:0] w_p0;
    logic [DW-1:0] r_days0;
    logic [16:0]   r_tl0, r_sod1, r_sod2;
    logic [34:0]   w_ph;
    logic [24:0]   w_pm;
    logic [4:0]    r_hr2, r_hr3, r_hr4;
    logic [11:0]   r_rs3, r_rs4;
    logic [5:0]    r_min4;
    e2c_pkg::t_tod r_tod5, r_tod6, r_tod7, r_tod8;

    always_comb begin
        w_en[NSTG-1] = !r_vld[NSTG-1] || o_rsp.ready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            w_en[i] = !r_vld[i] || w_en[i+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_req.valid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (w_en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    assign i_req.ready = w_en[0];
    assign o_rsp.valid = r_vld[NSTG-1];

    always_comb begin
        w_p0 = (2*XW+1)'(i_req.epoch_seconds[EPOCH_WIDTH-1:e2c_pkg::DAY_SHIFT])
             * (2*XW+1)'(DayM);
        w_ph = 35'(r_sod1) * 35'(e2c_pkg::M_HOUR);
        w_pm = 25'(r_rs3) * 25'(e2c_pkg::M_MIN);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_days0 <= w_p0[DayK +: DW];
            r_tl0   <= i_req.epoch_seconds[16:0];
        end
        if (w_en[1]) begin
            r_sod1 <= r_tl0 - 17'(17'(r_days0) * 17'(e2c_pkg::SEC_PER_DAY));
        end
        if (w_en[2]) begin
            r_hr2  <= w_ph[33:29];
            r_sod2 <= r_sod1;
        end
        if (w_en[3]) begin
            r_rs3 <= 12'(r_sod2 - 17'(r_hr2) * 17'(e2c_pkg::SEC_PER_HOUR));
            r_hr3 <= r_hr2;
        end
        if (w_en[4]) begin
            r_min4 <= w_pm[23:18];
            r_rs4  <= r_rs3;
            r_hr4  <= r_hr3;
        end
        if (w_en[5]) begin
            r_tod5.second <= 6'(r_rs4 - 12'(r_min4) * 12'(e2c_pkg::SEC_PER_MIN));
            r_tod5.minute <= r_min4;
            r_tod5.hour   <= r_hr4;
        end
        if (w_en[6]) begin
            r_tod6 <= r_tod5;
        end
        if (w_en[7]) begin
            r_tod7 <= r_tod6;
        end
        if (w_en[8]) begin
            r_tod8 <= r_tod7;
        end
    end

    e2c_civil #(
        .DW (DW),
        .ZW (ZW)
    ) u_civil (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_days  (r_days0),
        .o_year  (o_rsp.year),
        .o_month (o_rsp.month),
        .o_day   (o_rsp.day_of_month)
    );

    assign o_rsp.hour   = r_tod8.hour;
    assign o_rsp.minute = r_tod8.minute;
    assign o_rsp.second = r_tod8.second;

    `E2C_ASSERT_IMPLY(a_month_range, o_rsp.valid, o_rsp.month >= 4'd1 && o_rsp.month <= 4'd12)
    `E2C_ASSERT_IMPLY(a_day_range, o_rsp.valid, o_rsp.day_of_month >= 5'd1)
    `E2C_ASSERT_IMPLY(a_tod_range, o_rsp.valid, r_tod8.hour <= 5'd23 && r_tod8.minute <= 6'd59 && r_tod8.second <= 6'd59)
    `E2C_ASSERT_NEXT(a_accept_enters, i_req.valid && i_req.ready, r_vld[0])
    `E2C_ASSERT_NEXT(a_stall_holds, r_vld[NSTG-1] && !o_rsp.ready, r_vld[NSTG-1] && $stable(r_tod8))

endmodule

// ----- src/e2c_civil.sv -----
// Day count to Gregorian year, month and day, pipeline stages 1 to 8.
// Depends on e2c_pkg; stage enables come from the top-level valid chain.
`timescale 1ns / 1ps

module e2c_civil #(
    parameter int DW = 16,
    parameter int ZW = 20
) (
    input  logic              i_clk,
    input  e2c_pkg::t_stage_en i_en,
    input  logic [DW-1:0]     i_days,
    output logic [11:0]       o_year,
    output logic [3:0]        o_month,
    output logic [4:0]        o_day
);

    localparam int EW   = ZW - 17;
    localparam int EraK = ZW + 18;
    localparam logic [ZW:0] EraM =
        (ZW+1)'(((64'd1 << EraK) + 64'(e2c_pkg::DAYS_PER_ERA) - 64'd1)
                / 64'(e2c_pkg::DAYS_PER_ERA));

    logic [ZW-1:0] r_z1, r_z2;
    logic [EW-1:0] r_era2, r_era3, r_era4, r_era5;
    logic [17:0]   r_doe3, r_doe4, r_doe5, r_num4;
    logic [8:0]    r_yoe5, r_doy6, r_doy7;
    logic [11:0]   r_y6, r_y7;
    logic [3:0]    r_mp7;

    logic [2*ZW:0] w_pe;
    logic [36:0]   w_pq;
    logic [2:0]    w_cent;
    logic [38:0]   w_py;
    logic [18:0]   w_p100;
    logic [10:0]   w_n7, w_n8;
    logic [22:0]   w_pmp;
    logic [24:0]   w_pd;
    logic [3:0]    w_month;
    logic [11:0]   w_year;
    logic [4:0]    w_day;

    always_comb begin
        w_pe   = (2*ZW+1)'(r_z1) * (2*ZW+1)'(EraM);
        w_pq   = 37'(r_doe3) * 37'(e2c_pkg::M_1460);
        w_cent = 3'(r_doe3 >= 18'(e2c_pkg::DAYS_CENT))
               + 3'(r_doe3 >= 18'(2 * e2c_pkg::DAYS_CENT))
               + 3'(r_doe3 >= 18'(3 * e2c_pkg::DAYS_CENT))
               + 3'(r_doe3 >= 18'(4 * e2c_pkg::DAYS_CENT));
        w_py   = 39'(r_num4) * 39'(e2c_pkg::M_365);
        w_p100 = 19'(r_yoe5) * 19'(e2c_pkg::M_100);
        w_n7   = 11'(r_doy6) * 11'd5 + 11'd2;
        w_pmp  = 23'(w_n7) * 23'(e2c_pkg::M_153);
        w_n8   = 11'(r_mp7) * 11'd153 + 11'd2;
        w_pd   = 25'(w_n8) * 25'(e2c_pkg::M_DIV5);
        w_day  = 5'(r_doy7 - w_pd[24:16] + 9'd1);
        if (r_mp7 < 4'(e2c_pkg::MP_WRAP)) begin
            w_month = r_mp7 + 4'd3;
        end else begin
            w_month = r_mp7 - 4'(e2c_pkg::MP_WRAP - 1);
        end
        w_year = r_y7 + 12'(w_month <= 4'd2);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_z1 <= ZW'(i_days) + ZW'(e2c_pkg::CIVIL_OFFSET);
        end
        if (i_en[2]) begin
            r_era2 <= w_pe[EraK +: EW];
            r_z2   <= r_z1;
        end
        if (i_en[3]) begin
            r_doe3 <= 18'(r_z2 - ZW'(r_era2) * ZW'(e2c_pkg::DAYS_PER_ERA));
            r_era3 <= r_era2;
        end
        if (i_en[4]) begin
            r_num4 <= r_doe3 - 18'(w_pq[35:29]) + 18'(w_cent)
                    - 18'(r_doe3 == 18'(e2c_pkg::DAYS_PER_ERA - 1));
            r_doe4 <= r_doe3;
            r_era4 <= r_era3;
        end
        if (i_en[5]) begin
            r_yoe5 <= w_py[37:29];
            r_doe5 <= r_doe4;
            r_era5 <= r_era4;
        end
        if (i_en[6]) begin
            r_doy6 <= 9'(r_doe5 - (18'(r_yoe5) * 18'(e2c_pkg::DAYS_YEAR)
                    + 18'(r_yoe5[8:2]) - 18'(w_p100[17:16])));
            r_y6   <= 12'(r_era5) * 12'(e2c_pkg::YEARS_ERA) + 12'(r_yoe5);
        end
        if (i_en[7]) begin
            r_mp7  <= w_pmp[22:19];
            r_doy7 <= r_doy6;
            r_y7   <= r_y6;
        end
        if (i_en[8]) begin
            o_year  <= w_year;
            o_month <= w_month;
            o_day   <= w_day;
        end
    end

endmodule
